@@ hdl/bis_pkg.sv @@
// Shared constants for the bilinear image scaler.
package bis_pkg;

    localparam int POS_W      = 12;
    localparam int SMP_W      = 16;
    localparam int PORT_CH    = 4;
    localparam int FRAC_W     = 16;
    localparam int SRC_REG_W  = 9;
    localparam int DST_REG_W  = 13;
    localparam int SHIFT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_W      = DST_REG_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd5;

    localparam logic [SRC_REG_W-1:0] SRC_RESET = 9'd256;
    localparam logic [DST_REG_W-1:0] DST_RESET = 13'd256;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

endpackage

@@ hdl/bilinear_image_scaler.sv @@
// Top level of the bilinear image scaler: config registers, coordinate mapping, pipeline control.
//
// Bilinear image scaler with edge clamping. A load transaction (tuser = 0) writes one source
// pixel of up to four 16-bit channels into a four-bank frame store; a compute transaction
// (tuser = 1) names one destination pixel and yields one result transaction with the four
// blended channels. Each axis is mapped as (d + 0.5) * src / dst - shift - 0.5 in Q16; the
// four neighbors are read with coordinates clamped to the image edge. One transaction is
// accepted every cycle while the pipeline is not held. The Q16 source position is produced
// by a pipelined divider that yields one quotient bit per stage. Loads travel the same
// pipeline and write the store at the stage where computes read it, so results always see
// the loads accepted before them. The whole pipeline holds when the output register is full
// and m_tready is low. Write configuration only while no transaction is in flight.
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_SRC_DIM = 256,
    parameter int CHANNELS    = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x[11:0], pos_y[23:12], sample_0[39:24], sample_1[55:40], sample_2[71:56],
    // sample_3[87:72]
    input  logic [87:0]                 s_tdata,
    // kind[0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_0[15:0], out_1[31:16], out_2[47:32], out_3[63:48]
    output logic [63:0]                 m_tdata,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW  = $clog2(MAX_SRC_DIM);
    localparam int SW  = $clog2(MAX_SRC_DIM + 1);
    localparam int AW  = POS_W + 1 + SW;
    localparam int NW  = AW + FRAC_W;
    localparam int MW  = NW + 2;
    localparam int IW  = MW - FRAC_W;
    localparam int PD  = NW + 3;     // front pipeline: input, divider stages, map, clamp
    localparam int S2  = NW + 2;
    localparam int DW  = CHANNELS * SMP_W;

    // configuration registers
    logic [SRC_REG_W-1:0] src_width_reg, src_height_reg;
    logic [DST_REG_W-1:0] dst_width_reg, dst_height_reg;
    logic [SHIFT_W-1:0]   shift_x_reg, shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_RESET;
            src_height_reg <= SRC_RESET;
            dst_width_reg  <= DST_RESET;
            dst_height_reg <= DST_RESET;
            shift_x_reg    <= '0;
            shift_y_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_REG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_REG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_REG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_REG_W-1:0];
                REG_SHIFT_X:    shift_x_reg    <= cfg_data;
                REG_SHIFT_Y:    shift_y_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // effective sizes: source clamped to 1..MAX_SRC_DIM, destination zero acts as one
    function automatic logic [SW-1:0] eff_src(input logic [SRC_REG_W-1:0] v);
        logic [SW-1:0] r;
        if (v == '0)
            r = SW'(1);
        else if (32'(v) > MAX_SRC_DIM)
            r = SW'(MAX_SRC_DIM);
        else
            r = SW'(v);
        return r;
    endfunction

    function automatic logic [CW-1:0] clamp_c(input logic signed [IW-1:0] c,
                                              input logic [SW-1:0] sz);
        logic [CW-1:0] r;
        if (c < 0)
            r = '0;
        else if (c >= $signed(IW'(sz)))
            r = CW'(sz - SW'(1));
        else
            r = c[CW-1:0];
        return r;
    endfunction

    logic [SW-1:0]    sw, sh;
    logic [DIV_W-1:0] bx, by;

    assign sw = eff_src(src_width_reg);
    assign sh = eff_src(src_height_reg);
    assign bx = {(dst_width_reg  == '0) ? DST_REG_W'(1) : dst_width_reg, 1'b0};
    assign by = {(dst_height_reg == '0) ? DST_REG_W'(1) : dst_height_reg, 1'b0};

    // global advance: hold everything while a result waits and the sink is not ready
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // input unpack
    logic [POS_W-1:0] in_px, in_py;
    assign in_px = s_tdata[POS_W-1:0];
    assign in_py = s_tdata[2*POS_W-1:POS_W];

    // front pipeline sideband: valid bits and load payload
    logic          vld_reg  [PD];
    logic          kind_reg [PD];
    logic          ok_reg   [PD];
    logic [CW-1:0] lx_reg   [PD];
    logic [CW-1:0] ly_reg   [PD];
    logic [DW-1:0] smp_reg  [PD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PD; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < PD; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0] <= s_tuser;
            ok_reg[0]   <= (32'(in_px) < MAX_SRC_DIM) && (32'(in_py) < MAX_SRC_DIM);
            lx_reg[0]   <= in_px[CW-1:0];
            ly_reg[0]   <= in_py[CW-1:0];
            smp_reg[0]  <= s_tdata[2*POS_W +: DW];
            for (int k = 1; k < PD; k++)
            begin
                kind_reg[k] <= kind_reg[k-1];
                ok_reg[k]   <= ok_reg[k-1];
                lx_reg[k]   <= lx_reg[k-1];
                ly_reg[k]   <= ly_reg[k-1];
                smp_reg[k]  <= smp_reg[k-1];
            end
        end
    end

    // first stage: (2d + 1) * src
    logic [AW-1:0] ax_reg, ay_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= AW'({in_px, 1'b1}) * AW'(sw);
            ay_reg <= AW'({in_py, 1'b1}) * AW'(sh);
        end
    end

    // divide by 2 * dst, one quotient bit per stage
    logic [NW-1:0] qx, qy;

    bis_div #(.AW(AW)) u_div_x (.clk(clk), .en(en), .a(ax_reg), .b(bx), .q(qx));
    bis_div #(.AW(AW)) u_div_y (.clk(clk), .en(en), .a(ay_reg), .b(by), .q(qy));

    // subtract shift and half a pixel; split integer part and fraction
    logic signed [MW-1:0] mx, my;
    logic signed [IW-1:0] ix_reg, iy_reg;
    logic [FRAC_W-1:0]    fx_reg, fy_reg;

    assign mx = $signed({2'b00, qx}) - ($signed(MW'($signed(shift_x_reg))) <<< 8)
              - MW'(32768);
    assign my = $signed({2'b00, qy}) - ($signed(MW'($signed(shift_y_reg))) <<< 8)
              - MW'(32768);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_reg <= mx[MW-1:FRAC_W];
            iy_reg <= my[MW-1:FRAC_W];
            fx_reg <= mx[FRAC_W-1:0];
            fy_reg <= my[FRAC_W-1:0];
        end
    end

    // clamp neighbors to the image edge
    logic [CW-1:0]     x1_reg, x2_reg, y1_reg, y2_reg;
    logic [FRAC_W-1:0] fx2_reg, fy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= clamp_c(ix_reg, sw);
            x2_reg  <= clamp_c(ix_reg + IW'(1), sw);
            y1_reg  <= clamp_c(iy_reg, sh);
            y2_reg  <= clamp_c(iy_reg + IW'(1), sh);
            fx2_reg <= fx_reg;
            fy2_reg <= fy_reg;
        end
    end

    // frame store: loads write and computes read at the same stage, keeping order
    logic          st_wr;
    logic [DW-1:0] p_tl, p_tr, p_bl, p_br;

    assign st_wr = vld_reg[S2] && (kind_reg[S2] == KIND_LOAD) && ok_reg[S2];

    bis_store #(.MAX_SRC_DIM(MAX_SRC_DIM), .CHANNELS(CHANNELS)) u_store
    (
        .clk   (clk),
        .en    (en),
        .wr    (st_wr),
        .wx    (lx_reg[S2]),
        .wy    (ly_reg[S2]),
        .wdata (smp_reg[S2]),
        .x1    (x1_reg),
        .x2    (x2_reg),
        .y1    (y1_reg),
        .y2    (y2_reg),
        .p_tl  (p_tl),
        .p_tr  (p_tr),
        .p_bl  (p_bl),
        .p_br  (p_br)
    );

    // back pipeline: only compute transactions carry on as results
    logic              vm_reg;
    logic [FRAC_W-1:0] fxm_reg, fym_reg;
    logic              vb_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                vb_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vm_reg    <= vld_reg[S2] && (kind_reg[S2] == KIND_COMPUTE);
            vb_reg[0] <= vm_reg;
            vb_reg[1] <= vb_reg[0];
            vb_reg[2] <= vb_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fxm_reg <= fx2_reg;
            fym_reg <= fy2_reg;
        end
    end

    logic [PORT_CH*SMP_W-1:0] blend_out;

    bis_blend #(.CHANNELS(CHANNELS)) u_blend
    (
        .clk    (clk),
        .en     (en),
        .p_tl   (p_tl),
        .p_tr   (p_tr),
        .p_bl   (p_bl),
        .p_br   (p_br),
        .fx     (fxm_reg),
        .fy     (fym_reg),
        .result (blend_out)
    );

    // output register
    logic [PORT_CH*SMP_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vb_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= blend_out;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/bis_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, numerator scaled by 2^16.
module bis_div
    import bis_pkg::*;
#(
    parameter int AW = 22
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [AW-1:0]            a,
    input  logic [DIV_W-1:0]         b,
    output logic [AW+FRAC_W-1:0]     q
);

    localparam int NW = AW + FRAC_W;

    logic [DIV_W-1:0] rem_reg  [NW];
    logic [NW-1:0]    nq_reg   [NW];
    logic [DIV_W-1:0] rem_next [NW];
    logic [NW-1:0]    nq_next  [NW];

    always_comb
    begin
        logic [DIV_W-1:0] rin;
        logic [NW-1:0]    nin;
        logic [DIV_W:0]   trial;
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                rin = '0;
                nin = {a, {FRAC_W{1'b0}}};
            end
            else
            begin
                rin = rem_reg[k-1];
                nin = nq_reg[k-1];
            end
            trial = {rin, nin[NW-1]};
            if (trial >= {1'b0, b})
            begin
                rem_next[k] = DIV_W'(trial - {1'b0, b});
                nq_next[k]  = {nin[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DIV_W-1:0];
                nq_next[k]  = {nin[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
            end
        end
    end

    assign q = nq_reg[NW-1];

endmodule

@@ hdl/bis_store.sv @@
// Frame store split into four banks by row and column parity; four neighbors read per cycle while en is high.
module bis_store
    import bis_pkg::*;
#(
    parameter int MAX_SRC_DIM = 256,
    parameter int CHANNELS    = 4
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic                              wr,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    wx,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    wy,
    input  logic [CHANNELS*SMP_W-1:0]         wdata,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    x1,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    x2,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    y1,
    input  logic [$clog2(MAX_SRC_DIM)-1:0]    y2,
    output logic [CHANNELS*SMP_W-1:0]         p_tl,
    output logic [CHANNELS*SMP_W-1:0]         p_tr,
    output logic [CHANNELS*SMP_W-1:0]         p_bl,
    output logic [CHANNELS*SMP_W-1:0]         p_br
);

    localparam int CW    = $clog2(MAX_SRC_DIM);
    localparam int HALF  = (MAX_SRC_DIM + 1) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = CHANNELS * SMP_W;

    logic [DW-1:0] rd_data [4];
    logic          x1p_reg, x2p_reg, y1p_reg, y2p_reg;
    logic [ADW-1:0] waddr;

    assign waddr = ADW'(32'(wy >> 1) * HALF + 32'(wx >> 1));

    for (genvar bk = 0; bk < 4; bk++)
    begin : g_bank
        localparam logic BX = 1'(bk % 2);
        localparam logic BY = 1'(bk / 2);
        logic [DW-1:0]  bank_mem [DEPTH];
        logic [DW-1:0]  rd_reg;
        logic [CW-1:0]  xs, ys;
        logic [ADW-1:0] raddr;
        logic           wsel;

        assign xs    = (x1[0] == BX) ? x1 : x2;
        assign ys    = (y1[0] == BY) ? y1 : y2;
        assign raddr = ADW'(32'(ys >> 1) * HALF + 32'(xs >> 1));
        assign wsel  = wr && (wx[0] == BX) && (wy[0] == BY);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wsel)
                begin
                    bank_mem[waddr] <= wdata;
                end
                rd_reg <= bank_mem[raddr];
            end
        end

        assign rd_data[bk] = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1p_reg <= x1[0];
            x2p_reg <= x2[0];
            y1p_reg <= y1[0];
            y2p_reg <= y2[0];
        end
    end

    assign p_tl = rd_data[{y1p_reg, x1p_reg}];
    assign p_tr = rd_data[{y1p_reg, x2p_reg}];
    assign p_bl = rd_data[{y2p_reg, x1p_reg}];
    assign p_br = rd_data[{y2p_reg, x2p_reg}];

endmodule

@@ hdl/bis_blend.sv @@
// Three-stage bilinear blend per channel with round half up and clamp.
module bis_blend
    import bis_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [CHANNELS*SMP_W-1:0]     p_tl,
    input  logic [CHANNELS*SMP_W-1:0]     p_tr,
    input  logic [CHANNELS*SMP_W-1:0]     p_bl,
    input  logic [CHANNELS*SMP_W-1:0]     p_br,
    input  logic [FRAC_W-1:0]             fx,
    input  logic [FRAC_W-1:0]             fy,
    output logic [PORT_CH*SMP_W-1:0]      result
);

    logic [FRAC_W-1:0] fy1_reg, fy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fy1_reg <= fy;
            fy2_reg <= fy1_reg;
        end
    end

    for (genvar c = 0; c < PORT_CH; c++)
    begin : g_ch
        if (c < CHANNELS)
        begin : g_used
            logic [SMP_W-1:0]  tl_reg, bl_reg;
            logic signed [33:0] pt_reg, pb_reg;
            logic [31:0]       top_reg, bot_reg, top3_reg;
            logic signed [49:0] pr_reg;
            logic signed [16:0] dt, db;
            logic signed [34:0] top_w, bot_w;
            logic signed [32:0] dv;
            logic signed [50:0] sum;

            assign dt = $signed({1'b0, p_tr[c*SMP_W +: SMP_W]})
                      - $signed({1'b0, p_tl[c*SMP_W +: SMP_W]});
            assign db = $signed({1'b0, p_br[c*SMP_W +: SMP_W]})
                      - $signed({1'b0, p_bl[c*SMP_W +: SMP_W]});
            assign top_w = $signed({3'b0, tl_reg, 16'b0}) + 35'(pt_reg);
            assign bot_w = $signed({3'b0, bl_reg, 16'b0}) + 35'(pb_reg);
            assign dv    = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
            assign sum   = $signed({3'b0, top3_reg, 16'b0}) + 51'(pr_reg)
                         + 51'sh0_8000_0000;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    // horizontal blend of top and bottom rows
                    tl_reg   <= p_tl[c*SMP_W +: SMP_W];
                    bl_reg   <= p_bl[c*SMP_W +: SMP_W];
                    pt_reg   <= dt * $signed({1'b0, fx});
                    pb_reg   <= db * $signed({1'b0, fx});
                    top_reg  <= top_w[31:0];
                    bot_reg  <= bot_w[31:0];
                    // vertical blend
                    top3_reg <= top_reg;
                    pr_reg   <= dv * $signed({1'b0, fy2_reg});
                end
            end

            always_comb
            begin
                if (sum[50])
                begin
                    result[c*SMP_W +: SMP_W] = '0;
                end
                else if (|sum[49:48])
                begin
                    result[c*SMP_W +: SMP_W] = '1;
                end
                else
                begin
                    result[c*SMP_W +: SMP_W] = sum[47:32];
                end
            end
        end
        else
        begin : g_unused
            assign result[c*SMP_W +: SMP_W] = '0;
        end
    end

endmodule
